### design/mcss_pkg.sv
// Shared types and constants for the minimum chunk size search block.
// Used by every module under design/; depends on nothing else.

package mcss_pkg;

   localparam int MAX_ITEMS  = 1024;
   localparam int COUNT_BITS = 30;
   localparam int RECV_BITS  = 30;

   localparam int ADDR_BITS  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int LOAD_BITS  = $clog2(MAX_ITEMS + 1);
   localparam int ACC_BITS   = COUNT_BITS + $clog2(MAX_ITEMS + 1);
   localparam int STEP_BITS  = $clog2(COUNT_BITS + 1);
   localparam int DATA_BITS  = ((COUNT_BITS + 7) / 8) * 8;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_INIT,
      ST_CHECK,
      ST_READ,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_UPDATE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic search_init;
      logic pass_start;
      logic read_issue;
      logic div_start;
      logic accumulate;
      logic bound_update;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic search_open;
      logic pass_end;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

### design/mcss_div.sv
// Iterative restoring divider, one quotient bit per cycle, giving ceiling(a/b).
// Depends on mcss_pkg.

module mcss_div
   import mcss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [COUNT_BITS-1:0] dividend,
   input  logic [COUNT_BITS-1:0] divisor,
   output logic                  done,
   output logic [COUNT_BITS-1:0] quot_ceil
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [COUNT_BITS-1:0] quo_ff, quo_in;
   logic [COUNT_BITS-1:0] dvs_ff, dvs_in;

   logic [COUNT_BITS:0]   shifted;
   logic [COUNT_BITS:0]   diff;
   logic                  ge;

   // shift in the next dividend bit, subtract when it fits
   always_comb begin
      shifted = {rem_ff, quo_ff[COUNT_BITS-1]};
      diff    = shifted - {1'b0, dvs_ff};
      ge      = (shifted >= {1'b0, dvs_ff});
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_BITS'(COUNT_BITS);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
         quo_in  = {quo_ff[COUNT_BITS-2:0], ge};
         step_in = step_ff - STEP_BITS'(1);
         if (step_ff == STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   // round up when anything is left over
   assign quot_ceil = quo_ff + COUNT_BITS'(rem_ff != '0);

endmodule

### design/mcss_dp.sv
// Datapath: item store, running maximum, search bounds, chunk accumulator,
// receivers register and result register. Depends on mcss_pkg and mcss_div.

module mcss_dp
   import mcss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [COUNT_BITS-1:0] item_count,
   input  logic                  csr_write_enable,
   input  logic [RECV_BITS-1:0]  csr_write_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COUNT_BITS-1:0] chunk_size,
   output logic                  items_dropped
);

   logic [COUNT_BITS-1:0] mem [MAX_ITEMS];
   logic [COUNT_BITS-1:0] rd_ff;

   logic [LOAD_BITS-1:0]  loaded_ff, loaded_in;
   logic [COUNT_BITS-1:0] largest_ff, largest_in;
   logic                  overflow_ff, overflow_in;
   logic [COUNT_BITS-1:0] low_ff, low_in;
   logic [COUNT_BITS-1:0] high_ff, high_in;
   logic [COUNT_BITS-1:0] mid_ff, mid_in;
   logic [LOAD_BITS-1:0]  idx_ff, idx_in;
   logic [ACC_BITS-1:0]   acc_ff, acc_in;
   logic [RECV_BITS-1:0]  recv_ff, recv_in;
   logic                  valid_ff, valid_in;
   logic [COUNT_BITS-1:0] chunk_ff, chunk_in;
   logic                  drop_ff, drop_in;

   logic                  store_full;
   logic                  mem_write;
   logic [COUNT_BITS:0]   bound_sum;
   logic                  div_done;
   logic [COUNT_BITS-1:0] div_ceil;

   mcss_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (rd_ff),
      .divisor   (mid_ff),
      .done      (div_done),
      .quot_ceil (div_ceil)
   );

   assign store_full = (loaded_ff == LOAD_BITS'(MAX_ITEMS));
   assign mem_write  = cmd.load && !store_full;
   assign bound_sum  = {1'b0, low_ff} + {1'b0, high_ff};

   always_ff @(posedge clock) begin
      if (mem_write) begin
         mem[loaded_ff[ADDR_BITS-1:0]] <= item_count;
      end
      rd_ff <= mem[idx_ff[ADDR_BITS-1:0]];
   end

   always_comb begin
      loaded_in   = loaded_ff;
      largest_in  = largest_ff;
      overflow_in = overflow_ff;
      low_in      = low_ff;
      high_in     = high_ff;
      mid_in      = mid_ff;
      idx_in      = idx_ff;
      acc_in      = acc_ff;
      recv_in     = csr_write_enable ? csr_write_data : recv_ff;
      valid_in    = valid_ff && !rsp_ready;
      chunk_in    = chunk_ff;
      drop_in     = drop_ff;

      if (cmd.load) begin
         if (store_full) begin
            overflow_in = 1'b1;
         end else begin
            loaded_in = loaded_ff + LOAD_BITS'(1);
            if (item_count > largest_ff) begin
               largest_in = item_count;
            end
         end
      end
      if (cmd.search_init) begin
         low_in  = COUNT_BITS'(1);
         high_in = largest_ff;
      end
      if (cmd.pass_start) begin
         mid_in = bound_sum[COUNT_BITS:1];
         idx_in = '0;
         acc_in = '0;
      end
      if (cmd.read_issue) begin
         idx_in = idx_ff + LOAD_BITS'(1);
      end
      if (cmd.accumulate) begin
         acc_in = acc_ff + ACC_BITS'(div_ceil);
      end
      if (cmd.bound_update) begin
         if (acc_ff <= ACC_BITS'(recv_ff)) begin
            high_in = mid_ff;
         end else begin
            low_in = mid_ff + COUNT_BITS'(1);
         end
      end
      if (cmd.emit) begin
         valid_in    = 1'b1;
         chunk_in    = low_ff;
         drop_in     = overflow_ff;
         loaded_in   = '0;
         largest_in  = '0;
         overflow_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff   <= '0;
         largest_ff  <= '0;
         overflow_ff <= 1'b0;
         low_ff      <= COUNT_BITS'(1);
         high_ff     <= '0;
         recv_ff     <= RECV_BITS'(1);
         valid_ff    <= 1'b0;
      end else begin
         loaded_ff   <= loaded_in;
         largest_ff  <= largest_in;
         overflow_ff <= overflow_in;
         low_ff      <= low_in;
         high_ff     <= high_in;
         recv_ff     <= recv_in;
         valid_ff    <= valid_in;
      end
      mid_ff   <= mid_in;
      idx_ff   <= idx_in;
      acc_ff   <= acc_in;
      chunk_ff <= chunk_in;
      drop_ff  <= drop_in;
   end

   always_comb begin
      status.search_open = (low_ff < high_ff);
      status.pass_end    = (idx_ff == loaded_ff);
      status.div_done    = div_done;
      status.out_free    = !valid_ff || rsp_ready;
   end

   assign rsp_valid     = valid_ff;
   assign chunk_size    = chunk_ff;
   assign items_dropped = drop_ff;

endmodule

### design/mcss_ctrl.sv
// Controller state machine: sequences loading, the binary search passes and
// the result hand-off. Depends on mcss_pkg.

module mcss_ctrl
   import mcss_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_last,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      take;

   assign take = req_valid && (state_ff == ST_LOAD);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (take && req_last) begin
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = status.search_open ? ST_READ : ST_EMIT;
         end
         ST_READ: begin
            state_in = ST_DIV_START;
         end
         ST_DIV_START: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               state_in = status.pass_end ? ST_UPDATE : ST_READ;
            end
         end
         ST_UPDATE: begin
            state_in = ST_CHECK;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            cmd.load  = take;
         end
         ST_INIT: begin
            cmd.search_init = 1'b1;
         end
         ST_CHECK: begin
            cmd.pass_start = status.search_open;
         end
         ST_READ: begin
            cmd.read_issue = 1'b1;
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
         end
         ST_DIV_WAIT: begin
            cmd.accumulate = status.div_done;
         end
         ST_UPDATE: begin
            cmd.bound_update = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### design/min_chunk_size_search.sv
// Top level of the minimum chunk size search block.
// Depends on mcss_pkg, mcss_ctrl and mcss_dp.
//
// Usage:
//   Stream a set of item counts in on the req_ channel, one transaction per
//   item; tlast marks the final item of the set. Up to MAX_ITEMS items are
//   stored; later items of the same set are dropped and flagged.
//   After the last item the block binary-searches chunk sizes from 1 to the
//   largest count and returns one transaction on the rsp_ channel: the
//   smallest size whose sum of ceiling(count/size) is no more than the
//   receivers register, and a flag telling whether items were dropped.
//   Loading accepts an item whenever req_tvalid is high (req_tready stays
//   high while loading). The search runs up to COUNT_BITS passes; each pass
//   reads the stored items one at a time through the single store read port,
//   divides each in the bit-serial divider, then updates the bounds.
//   req_tready is low from the last item until the result is in the output
//   register. The output register lets the next set load while a result
//   waits; a stalled receiver only holds the block once a further result is
//   ready. Reset (synchronous) empties the set, clears the output register
//   and sets receivers to 1. Write csr_ only while the block is idle.

module min_chunk_size_search
   import mcss_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // Input channel
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [DATA_BITS-1:0] req_tdata,   // [COUNT_BITS-1:0] item_count
   input  logic                 req_tlast,   // last_item
   // Result channel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [DATA_BITS-1:0] rsp_tdata,   // [COUNT_BITS-1:0] chunk_size
   output logic [0:0]           rsp_tuser,   // [0] items_dropped
   // Receivers register
   input  logic                 csr_write_enable,
   input  logic [RECV_BITS-1:0] csr_write_data
);

   cmd_type               cmd;
   status_type            status;
   logic [COUNT_BITS-1:0] chunk_size;
   logic                  items_dropped;

   // Sequence load, search passes and hand-off
   mcss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_last  (req_tlast),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   // Hold the store, bounds, accumulator and result register
   mcss_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .item_count       (req_tdata[COUNT_BITS-1:0]),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_tvalid),
      .rsp_ready        (rsp_tready),
      .chunk_size       (chunk_size),
      .items_dropped    (items_dropped)
   );

   // Pad the result up to whole bytes
   assign rsp_tdata = DATA_BITS'(chunk_size);
   assign rsp_tuser = items_dropped;

endmodule

### tb/testbench.sv
// Self-checking testbench for min_chunk_size_search.
// Depends on mcss_pkg and the RTL under design/; predicts each chunk size from its own
// copy of the set and the receivers register and checks every rsp_ transaction in order.
`timescale 1ns / 100ps

module testbench;
   import mcss_pkg::*;

   localparam int          HALF_PERIOD = 5;
   localparam int          RESET_CYCLES = 6;
   localparam int          SETTLE_CYCLES = 40;     // covers a load cycle and the emit path
   localparam int          HOLD_OFF_CYCLES = 3000; // long receiver stall for backpressure
   localparam int          QUIET_LIMIT = 400000;   // watchdog limit for a stretch with no transaction
   localparam int          RANDOM_ITEMS = 150;
   localparam int          PHASE_COUNT = 5;
   localparam int          MAX_REPORTS = 10;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [RECV_BITS-1:0]  RECV_MAX = '1;

   typedef struct packed {
      logic [COUNT_BITS-1:0] chunk_size;
      logic                  dropped;
   } chunk_answer_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [DATA_BITS-1:0] req_tdata;   // [COUNT_BITS-1:0] item_count
   logic                 req_tlast;   // last_item
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [DATA_BITS-1:0] rsp_tdata;   // [COUNT_BITS-1:0] chunk_size
   logic [0:0]           rsp_tuser;   // [0] items_dropped
   logic                 csr_write_enable;
   logic [RECV_BITS-1:0] csr_write_data;

   // Predictor state: counts of the set being loaded, its peak, the drop flag
   // and a shadow of the receivers register.
   logic [COUNT_BITS-1:0] set_counts[$];
   logic [COUNT_BITS-1:0] set_peak;
   logic                  set_overflow;
   logic [RECV_BITS-1:0]  receivers_shadow;
   chunk_answer_type      awaited_answers[$];

   // Traffic shaping knobs, flipped by the test tasks.
   bit sender_gaps_on;
   bit receiver_gaps_on;
   bit hold_off_request;

   int unsigned items_taken;
   int unsigned answers_checked;
   int unsigned dropped_answers;
   int unsigned receiver_settings;
   int unsigned hold_offs_done;
   int unsigned mismatch_count;
   int unsigned quiet_cycles;

   min_chunk_size_search dut (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tlast        (req_tlast),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // Sum of ceil(count / size) over the stored counts of the current set.
   function automatic longint unsigned chunks_needed(logic [COUNT_BITS-1:0] size);
      longint unsigned total;
      total = 0;
      foreach (set_counts[i])
         total += (64'(set_counts[i]) + 64'(size) - 64'd1) / 64'(size);
      return total;
   endfunction

   // Binary search on the answer: smallest size in [1, peak] that fits the receivers.
   function automatic logic [COUNT_BITS-1:0] smallest_chunk_size();
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      lo = 1;
      hi = 64'(set_peak);
      while (lo < hi) begin
         mid = (lo + hi) / 2;
         if (chunks_needed(mid[COUNT_BITS-1:0]) <= 64'(receivers_shadow))
            hi = mid;
         else
            lo = mid + 1;
      end
      return lo[COUNT_BITS-1:0];
   endfunction

   // Fold one accepted item into the set; on the last item queue the expected answer.
   function automatic void absorb_item(logic [COUNT_BITS-1:0] count, logic last);
      chunk_answer_type answer;
      if (set_counts.size() < MAX_ITEMS) begin
         set_counts = {set_counts, count};
         if (count > set_peak)
            set_peak = count;
      end else begin
         set_overflow = 1'b1;
      end
      if (last) begin
         answer.chunk_size = smallest_chunk_size();
         answer.dropped    = set_overflow;
         awaited_answers   = {awaited_answers, answer};
         set_counts.delete();
         set_peak     = '0;
         set_overflow = 1'b0;
      end
   endfunction

   // Track the input side and the register at each rising edge.
   always @(posedge clock) begin
      if (reset) begin
         set_counts.delete();
         set_peak         = '0;
         set_overflow     = 1'b0;
         receivers_shadow = RECV_BITS'(1);
      end else begin
         if (csr_write_enable)
            receivers_shadow = csr_write_data;
         if (req_tvalid && req_tready) begin
            items_taken++;
            absorb_item(req_tdata[COUNT_BITS-1:0], req_tlast);
         end
      end
   end

   // Check every result transaction against the oldest expected answer.
   always @(posedge clock) begin
      chunk_answer_type wanted;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_answers.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected result: chunk_size %0d items_dropped %0b",
                        rsp_tdata[COUNT_BITS-1:0], rsp_tuser[0]);
         end else begin
            wanted = awaited_answers.pop_front();
            answers_checked++;
            if (rsp_tuser[0])
               dropped_answers++;
            if (rsp_tdata[COUNT_BITS-1:0] !== wanted.chunk_size ||
                rsp_tuser[0] !== wanted.dropped) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display({"mismatch on result %0d: expected size %0d dropped %0b, ",
                            "got size %0d dropped %0b"},
                           answers_checked, wanted.chunk_size, wanted.dropped,
                           rsp_tdata[COUNT_BITS-1:0], rsp_tuser[0]);
            end
         end
      end
   end

   // Watchdog: end the run when no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles, %0d answers outstanding",
                  quiet_cycles, awaited_answers.size());
         $display("status: fail");
         $finish;
      end
   end

   // Receiver: draw a stall before each result, or take the long hold-off when asked.
   initial begin
      int unsigned stall;
      rsp_tready = 1'b0;
      forever begin
         if (hold_off_request) begin
            stall = HOLD_OFF_CYCLES;
            hold_off_request = 1'b0;
            hold_offs_done++;
         end else begin
            stall = receiver_gaps_on ? $urandom_range(0, 15) : 0;
         end
         @(negedge clock);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (reset || !rsp_tvalid);
      end
   end

   // Send one item. Returns right after the accepting edge with tvalid still high,
   // so a back-to-back item keeps tvalid up without a drop in between.
   task automatic send_item(logic [COUNT_BITS-1:0] count, logic last);
      int unsigned gap;
      gap = sender_gaps_on ? $urandom_range(0, 15) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(DATA_BITS - COUNT_BITS){1'b0}}, count};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop tvalid, wait until every expected answer has come back, then let the block settle.
   task automatic drain_block();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (awaited_answers.size() > 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write the receivers register; only called with the block idle.
   task automatic write_receivers(logic [RECV_BITS-1:0] value);
      drain_block();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      receiver_settings++;
   endtask

   // Mostly counts of random bit width, so search depth varies; zeros and the
   // maximum show up often.
   function automatic logic [COUNT_BITS-1:0] random_count();
      logic [COUNT_BITS-1:0] mask;
      case ($urandom_range(0, 7))
         0: return '0;
         1: return COUNT_MAX;
         default: begin
            mask = COUNT_MAX >> (COUNT_BITS - $urandom_range(1, COUNT_BITS));
            return COUNT_BITS'($urandom) & mask;
         end
      endcase
   endfunction

   task automatic send_set(int unsigned length);
      for (int unsigned i = 0; i < length; i++)
         send_item(random_count(), i == length - 1);
   endtask

   // Field extremes, single-item sets, all zeros, too many nonzero items for the
   // receivers, and the largest receivers setting.
   task automatic test_directed();
      send_item('0, 1'b1);
      send_item(COUNT_MAX, 1'b1);
      send_item(1, 1'b1);
      send_item(6, 1'b0);
      send_item(0, 1'b0);
      send_item(9, 1'b1);
      write_receivers(4);
      send_item(7, 1'b0);
      send_item(3, 1'b0);
      send_item(10, 1'b0);
      send_item(1, 1'b1);
      send_item(0, 1'b0);
      send_item(0, 1'b0);
      send_item(0, 1'b1);
      write_receivers(RECV_MAX);
      send_item(COUNT_MAX, 1'b0);
      send_item(COUNT_MAX, 1'b0);
      send_item(5, 1'b1);
      write_receivers(2);
      send_item(COUNT_MAX, 1'b0);
      send_item(1, 1'b1);
      drain_block();
   endtask

   // Fill the store, then push two more items: a large one that must not raise
   // the peak, and a last one that is itself dropped. The next set must be clean.
   task automatic test_overflow();
      write_receivers(1500);
      for (int i = 0; i < MAX_ITEMS - 1; i++)
         send_item(COUNT_BITS'($urandom_range(0, 3)), 1'b0);
      send_item(3, 1'b0);
      send_item(1000, 1'b0);
      send_item(COUNT_MAX, 1'b1);
      send_item(5, 1'b1);
      drain_block();
   endtask

   // Random sets under several receiver settings and idling mixes.
   task automatic test_random_sets();
      int unsigned sent;
      int unsigned length;
      logic [RECV_BITS-1:0] setting;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: setting = 1;
            1: setting = RECV_BITS'($urandom_range(2, 8));
            2: setting = RECV_BITS'($urandom_range(9, 200));
            3: setting = RECV_MAX;
            default: setting = RECV_BITS'($urandom_range(1, RECV_MAX));
         endcase
         write_receivers(setting);
         // Phase 3 runs with no idling on either side.
         sender_gaps_on   = (phase != 1) && (phase != 3);
         receiver_gaps_on = (phase != 2) && (phase != 3);
         sent = 0;
         while (sent < RANDOM_ITEMS / PHASE_COUNT) begin
            length = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16)
                                                 : $urandom_range(1, 6);
            send_set(length);
            sent += length;
         end
      end
      sender_gaps_on   = 1'b1;
      receiver_gaps_on = 1'b1;
      drain_block();
   endtask

   // Hold the receiver off while the sender streams sets back to back: the output
   // register fills, the next result waits, and req_tready has to stall.
   task automatic test_backpressure();
      write_receivers(RECV_BITS'($urandom_range(2, 12)));
      sender_gaps_on   = 1'b0;
      hold_off_request = 1'b1;
      for (int i = 0; i < 8; i++) begin
         send_item(COUNT_BITS'($urandom_range(0, 255)), 1'b0);
         send_item(COUNT_BITS'($urandom_range(0, 255)), 1'b0);
         send_item(COUNT_BITS'($urandom_range(0, 255)), 1'b1);
      end
      sender_gaps_on = 1'b1;
      drain_block();
   endtask

   initial begin
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      req_tlast        = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      sender_gaps_on   = 1'b1;
      receiver_gaps_on = 1'b1;
      hold_off_request = 1'b0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_overflow();
      test_random_sets();
      test_backpressure();

      // drain_block already waited for the last answer and the settle time.
      if (awaited_answers.size() > 0) begin
         mismatch_count++;
         $display("%0d expected answers never arrived", awaited_answers.size());
      end
      $display("covered %0d items, %0d answers (%0d with items dropped), %0d receiver settings",
               items_taken, answers_checked, dropped_answers, receiver_settings);
      $display("random idling on both sides, %0d long receiver hold-off(s), %0d failures",
               hold_offs_done, mismatch_count);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
